// File: sv/etwf_pkg.sv
// Package: widths, status codes, controller states, command/status structs, frame shift helper.
package etwf_pkg;

  localparam int WIRE_BITS   = 21;
  localparam int FRAME_W     = 21;
  localparam int TIME_W      = 32;
  localparam int TICK_W      = 16;
  localparam int CNT_W       = $clog2(WIRE_BITS + 1);
  localparam int STEP_W      = $clog2(CNT_W);
  localparam int REM_W       = TIME_W + 2;
  localparam int DEN_W       = TICK_W + 1;
  localparam int BIG_W       = DEN_W + CNT_W;
  localparam int IN_TDATA_W  = ((TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FRAME_W + 7) / 8) * 8;
  localparam int STAT_W      = 2;

  localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(640);

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_RUN = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SHIFT,
    S_FILL
  } state_t;

  typedef struct packed {
    logic              load;
    logic              check;
    logic              div_step;
    logic [STEP_W-1:0] step_idx;
    logic              shift;
    logic              emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic take;
    logic last;
    logic zero_run;
    logic too_big;
    logic out_free;
  } dp_sts_t;

  // shift n copies of level in at the low end, oldest bit ends up at the top
  function automatic logic [WIRE_BITS-1:0] shift_frame(
    input logic [WIRE_BITS-1:0] frame,
    input logic                 level,
    input logic [CNT_W-1:0]     n
  );
    logic [2*WIRE_BITS-1:0] wide;
    logic [2*WIRE_BITS-1:0] ones;
    wide = {{WIRE_BITS{1'b0}}, frame} << n;
    ones = ~({(2*WIRE_BITS){1'b1}} << n);
    if (level) begin
      wide = wide | ones;
    end
    return wide[WIRE_BITS-1:0];
  endfunction

endpackage

// File: sv/etwf_ctrl.sv
// Controller: sequences load, range check, quotient steps, frame shift and emit.
module etwf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  etwf_pkg::dp_sts_t   sts,
  output etwf_pkg::ctrl_cmd_t cmd
);

  etwf_pkg::state_t                  state_r, state_nxt;
  logic [etwf_pkg::STEP_W-1:0]       step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etwf_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      etwf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = etwf_pkg::S_CHECK;
        end
      end
      etwf_pkg::S_CHECK: begin
        if (sts.take && !sts.zero_run && !sts.too_big) begin
          state_nxt = etwf_pkg::S_DIV;
          step_nxt  = etwf_pkg::STEP_W'(etwf_pkg::CNT_W - 1);
        end else if (sts.last) begin
          state_nxt = etwf_pkg::S_FILL;
        end else begin
          state_nxt = etwf_pkg::S_IDLE;
        end
      end
      etwf_pkg::S_DIV: begin
        if (step_r == '0) begin
          state_nxt = etwf_pkg::S_SHIFT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      etwf_pkg::S_SHIFT: begin
        state_nxt = sts.last ? etwf_pkg::S_FILL : etwf_pkg::S_IDLE;
      end
      etwf_pkg::S_FILL: begin
        if (sts.out_free) begin
          state_nxt = etwf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = etwf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.step_idx = step_r;
    in_tready    = 1'b0;
    case (state_r)
      etwf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      etwf_pkg::S_CHECK: begin
        cmd.check = 1'b1;
      end
      etwf_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      etwf_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      etwf_pkg::S_FILL: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/etwf_dp.sv
// Datapath: reply state, run rounding by restoring quotient steps, frame shifter, output register.
module etwf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [etwf_pkg::TICK_W-1:0]         cfg_data,
  input  logic [etwf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  logic                                out_tready,
  input  etwf_pkg::ctrl_cmd_t                 cmd,
  output etwf_pkg::dp_sts_t                   sts,
  output logic                                out_tvalid,
  output logic [etwf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [etwf_pkg::STAT_W-1:0]         out_tuser
);

  logic [etwf_pkg::TICK_W-1:0]    ticks_r, ticks_nxt;
  logic [etwf_pkg::TIME_W-1:0]    prev_r, prev_nxt;
  logic                           have_prev_r, have_prev_nxt;
  logic                           level_r, level_nxt;
  logic [etwf_pkg::CNT_W-1:0]     filled_r, filled_nxt;
  logic [etwf_pkg::WIRE_BITS-1:0] frame_r, frame_nxt;
  logic [etwf_pkg::CNT_W-1:0]     edges_r, edges_nxt;
  logic [etwf_pkg::STAT_W-1:0]    err_r, err_nxt;
  logic                           last_r, last_nxt;
  logic                           take_r, take_nxt;
  logic [etwf_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [etwf_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [etwf_pkg::CNT_W-1:0]     quo_r, quo_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [etwf_pkg::FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic [etwf_pkg::STAT_W-1:0]    out_stat_r, out_stat_nxt;

  logic [etwf_pkg::STAT_W-1:0]    err_load;
  logic [etwf_pkg::TIME_W-1:0]    gap;
  logic [etwf_pkg::TICK_W-1:0]    tick_eff;
  logic [etwf_pkg::BIG_W-1:0]     big_lim;
  logic [etwf_pkg::REM_W-1:0]     trial;
  logic [etwf_pkg::CNT_W:0]       fill_sum;
  logic [etwf_pkg::CNT_W-1:0]     fill_n;
  logic                           zero_run;
  logic                           too_big;
  logic                           out_free;

  assign out_free = !out_valid_r || out_tready;
  assign tick_eff = (ticks_r == '0) ? etwf_pkg::TICK_W'(1) : ticks_r;
  assign gap      = in_tdata[etwf_pkg::TIME_W-1:0] - prev_r;
  assign err_load = (edges_r >= etwf_pkg::CNT_W'(etwf_pkg::WIRE_BITS)) ?
                    etwf_pkg::ST_TOO_MANY : err_r;
  assign big_lim  = etwf_pkg::BIG_W'(den_r) * etwf_pkg::BIG_W'(etwf_pkg::WIRE_BITS + 1);
  assign zero_run = rem_r < etwf_pkg::REM_W'(den_r);
  assign too_big  = rem_r >= etwf_pkg::REM_W'(big_lim);
  assign trial    = etwf_pkg::REM_W'(den_r) << cmd.step_idx;
  assign fill_sum = (etwf_pkg::CNT_W+1)'(filled_r) + (etwf_pkg::CNT_W+1)'(quo_r);
  assign fill_n   = etwf_pkg::CNT_W'(etwf_pkg::WIRE_BITS) - filled_r;

  always_comb begin
    sts.take     = take_r;
    sts.last     = last_r;
    sts.zero_run = zero_run;
    sts.too_big  = too_big;
    sts.out_free = out_free;
  end

  always_comb begin
    ticks_nxt     = cfg_valid ? cfg_data : ticks_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    level_nxt     = level_r;
    filled_nxt    = filled_r;
    frame_nxt     = frame_r;
    edges_nxt     = edges_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    take_nxt      = take_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    out_frame_nxt = out_frame_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    if (cmd.load) begin
      err_nxt       = err_load;
      if (err_load != etwf_pkg::ST_TOO_MANY) begin
        edges_nxt = edges_r + 1'b1;
      end
      take_nxt      = have_prev_r && (err_load == etwf_pkg::ST_OK) &&
                      (filled_r < etwf_pkg::CNT_W'(etwf_pkg::WIRE_BITS));
      prev_nxt      = in_tdata[etwf_pkg::TIME_W-1:0];
      have_prev_nxt = 1'b1;
      last_nxt      = in_tlast;
      rem_nxt       = {1'b0, gap, 1'b0} + etwf_pkg::REM_W'(tick_eff);
      den_nxt       = {tick_eff, 1'b0};
    end

    if (cmd.check) begin
      quo_nxt = '0;
      if (take_r && zero_run) begin
        err_nxt = etwf_pkg::ST_ZERO_RUN;
      end else if (take_r && too_big) begin
        err_nxt = etwf_pkg::ST_OVERFLOW;
      end
    end

    if (cmd.div_step && (rem_r >= trial)) begin
      rem_nxt                = rem_r - trial;
      quo_nxt[cmd.step_idx]  = 1'b1;
    end

    if (cmd.shift) begin
      if (fill_sum > (etwf_pkg::CNT_W+1)'(etwf_pkg::WIRE_BITS)) begin
        err_nxt = etwf_pkg::ST_OVERFLOW;
      end else begin
        frame_nxt  = etwf_pkg::shift_frame(frame_r, level_r, quo_r);
        filled_nxt = fill_sum[etwf_pkg::CNT_W-1:0];
        level_nxt  = !level_r;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_stat_nxt  = err_r;
      out_frame_nxt = (err_r == etwf_pkg::ST_OK) ?
                      etwf_pkg::FRAME_W'(etwf_pkg::shift_frame(frame_r, level_r, fill_n)) :
                      '0;
      have_prev_nxt = 1'b0;
      level_nxt     = 1'b0;
      filled_nxt    = '0;
      frame_nxt     = '0;
      edges_nxt     = '0;
      err_nxt       = etwf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= etwf_pkg::TICKS_RESET;
      have_prev_r <= 1'b0;
      level_r     <= 1'b0;
      filled_r    <= '0;
      frame_r     <= '0;
      edges_r     <= '0;
      err_r       <= etwf_pkg::ST_OK;
      last_r      <= 1'b0;
      take_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ticks_r     <= ticks_nxt;
      have_prev_r <= have_prev_nxt;
      level_r     <= level_nxt;
      filled_r    <= filled_nxt;
      frame_r     <= frame_nxt;
      edges_r     <= edges_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      take_r      <= take_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    out_frame_r <= out_frame_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = etwf_pkg::OUT_TDATA_W'(out_frame_r);
  assign out_tuser  = out_stat_r;

endmodule

// File: sv/edge_times_to_wire_frame.sv
// Top level: telemetry edge timestamps in, rebuilt 21-bit wire frame with status out.
//
// Input stream: one captured edge timestamp per request, in_tlast on the final
// edge of a reply. Each gap is rounded to a run of wire bits against run_ticks
// (cfg_data, reset 640, zero counts as one tick) and shifted into the frame.
// On the last edge the frame is completed with the final level and one result
// request is issued: out_tdata holds the frame (zero on error), out_tuser the
// status (ok, zero run, run overflow, too many edges).
// Per edge: load and check when no gap is taken; load, check, the CNT_W quotient
// steps of the shared subtractor and a shift when a gap is rounded.
// A last edge then passes through the fill state to write the output register.
// The output register holds a finished result while the next reply's edges are
// taken; a last edge waits in the fill state while the receiver stalls.
// cfg_ready is always high; write only between replies.
// Reset (rst_n low, synchronous) clears the reply state and restores run_ticks.
module edge_times_to_wire_frame (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [etwf_pkg::TICK_W-1:0]      cfg_data,     // run_ticks
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [etwf_pkg::IN_TDATA_W-1:0]  in_tdata,     // [31:0] edge_time
  input  logic                             in_tlast,     // last_edge
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [etwf_pkg::OUT_TDATA_W-1:0] out_tdata,    // [20:0] wire_frame, zero pad
  output logic [etwf_pkg::STAT_W-1:0]      out_tuser     // [1:0] status
);

  etwf_pkg::ctrl_cmd_t cmd;
  etwf_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  etwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etwf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  a_err_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != etwf_pkg::ST_OK)) |-> (out_tdata == '0))
    else $error("error status with non-zero frame");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result written over a pending request");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.emit))
    else $error("output valid without emit");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.shift || cmd.check) |-> !in_tready)
    else $error("input ready while an edge is in work");
`endif

endmodule

// File: bench/edge_times_to_wire_frame_test.sv
// Self-checking bench for the telemetry edge-time to wire-frame decoder, with stream stalls.
module edge_times_to_wire_frame_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {R_CLEAN, R_ZERO, R_OVER, R_MANY, R_LONE, R_NOISE} reply_kind_t;

  class reply_scoreboard;
    logic [etwf_pkg::TICK_W-1:0]      ticks;
    logic [etwf_pkg::TIME_W-1:0]      prev_edge;
    bit                               have_prev;
    bit                               level;
    int unsigned                      filled;
    int unsigned                      edges;
    logic [etwf_pkg::WIRE_BITS-1:0]   frame;
    logic [etwf_pkg::STAT_W-1:0]      err;
    logic [etwf_pkg::OUT_TDATA_W-1:0] want_frame[$];
    logic [etwf_pkg::STAT_W-1:0]      want_status[$];
    int unsigned                      bad;
    int unsigned                      results;
    int unsigned                      by_status[4];

    function new();
      ticks = etwf_pkg::TICKS_RESET;
      bad = 0;
      results = 0;
      foreach (by_status[i]) by_status[i] = 0;
      clear_reply();
    endfunction

    function void clear_reply();
      prev_edge = '0;
      have_prev = 0;
      level = 0;
      filled = 0;
      edges = 0;
      frame = '0;
      err = etwf_pkg::ST_OK;
    endfunction

    function void shift_level(int unsigned n);
      for (int unsigned i = 0; i < n; i++) frame = {frame[etwf_pkg::WIRE_BITS-2:0], level};
    endfunction

    function void round_gap(logic [etwf_pkg::TIME_W-1:0] width);
      longint unsigned t;
      longint unsigned w;
      longint unsigned run;
      if (err != etwf_pkg::ST_OK || filled >= etwf_pkg::WIRE_BITS) return;
      t = (ticks == 0) ? 1 : ticks;
      w = width;
      run = (2 * w + t) / (2 * t);
      if (run == 0) begin
        err = etwf_pkg::ST_ZERO_RUN;
        return;
      end
      if (filled + run > etwf_pkg::WIRE_BITS) begin
        err = etwf_pkg::ST_OVERFLOW;
        return;
      end
      shift_level(run);
      filled += run;
      level = !level;
    endfunction

    function void note_edge(logic [etwf_pkg::TIME_W-1:0] stamp, bit last);
      if (edges >= etwf_pkg::WIRE_BITS) err = etwf_pkg::ST_TOO_MANY;
      else edges++;
      if (have_prev && err != etwf_pkg::ST_TOO_MANY) round_gap(stamp - prev_edge);
      prev_edge = stamp;
      have_prev = 1;
      if (!last) return;
      if (err == etwf_pkg::ST_OK && filled < etwf_pkg::WIRE_BITS) begin
        shift_level(etwf_pkg::WIRE_BITS - filled);
        filled = etwf_pkg::WIRE_BITS;
      end
      want_frame.push_back((err == etwf_pkg::ST_OK) ? etwf_pkg::OUT_TDATA_W'(frame) : '0);
      want_status.push_back(err);
      clear_reply();
    endfunction

    function void check_result(logic [etwf_pkg::OUT_TDATA_W-1:0] got_frame,
                               logic [etwf_pkg::STAT_W-1:0] got_status);
      logic [etwf_pkg::OUT_TDATA_W-1:0] wf;
      logic [etwf_pkg::STAT_W-1:0]      ws;
      results++;
      if (want_frame.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected result frame %06h status %0d", $time, got_frame, got_status);
        return;
      end
      wf = want_frame.pop_front();
      ws = want_status.pop_front();
      by_status[ws]++;
      if (got_frame !== wf || got_status !== ws) begin
        bad++;
        if (bad <= 10)
          $display("%0t: result %0d mismatch: expected frame %06h status %0d, %s %06h %s %0d",
                   $time, results, wf, ws, "got frame", got_frame, "status", got_status);
      end
    endfunction

    function int unsigned pending();
      return want_frame.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [etwf_pkg::TICK_W-1:0]      cfg_data;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [etwf_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [etwf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [etwf_pkg::STAT_W-1:0]      out_tuser;

  reply_scoreboard sb = new();
  bit          idle_on = 1;
  int unsigned hold_ask = 0;
  int unsigned hold_left = 0;
  int unsigned edges_sent = 0;
  int unsigned replies = 0;

  edge_times_to_wire_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL edge_times_to_wire_frame");
    $finish;
  end

  // result side: checks each request, stalls at random or for a requested hold-off
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  function automatic int unsigned eff_ticks();
    return (sb.ticks == 0) ? 1 : sb.ticks;
  endfunction

  task automatic send_edge(logic [etwf_pkg::TIME_W-1:0] stamp, bit last);
    if (idle_on && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_edge(stamp, last);
    edges_sent++;
  endtask

  task automatic send_reply(reply_kind_t kind);
    logic [etwf_pkg::TIME_W-1:0] gaps[$];
    logic [etwf_pkg::TIME_W-1:0] stamp;
    int unsigned t;
    int unsigned room;
    int unsigned k;
    int unsigned n;
    int unsigned idx;
    t = eff_ticks();
    case (kind)
      R_CLEAN, R_ZERO, R_OVER: begin
        room = etwf_pkg::WIRE_BITS;
        while (room > 0 && gaps.size() < 20 &&
               !(gaps.size() > 0 && $urandom_range(11) == 0)) begin
          k = ($urandom_range(7) == 0) ? $urandom_range(1, room)
                                       : $urandom_range(1, (room < 4) ? room : 4);
          gaps.push_back(k * t - t / 2 + $urandom_range(0, t - 1));
          room -= k;
        end
        // full frame, trailing edges ignored
        if (room == 0 && gaps.size() < 18 && $urandom_range(3) == 0)
          repeat ($urandom_range(1, 2)) gaps.push_back($urandom_range(0, 3 * t));
        if (kind != R_CLEAN) begin
          if (gaps.size() == 0) gaps.push_back(t);
          idx = $urandom_range(0, gaps.size() - 1);
          if (kind == R_ZERO) gaps[idx] = $urandom_range(0, (t - 1) / 2);
          else if ($urandom_range(3) == 0) gaps[idx] = $urandom;
          else gaps[idx] = $urandom_range(etwf_pkg::WIRE_BITS + 1, etwf_pkg::WIRE_BITS + 40) * t;
        end
      end
      R_MANY: begin
        n = $urandom_range(etwf_pkg::WIRE_BITS - 1, etwf_pkg::WIRE_BITS + 7);
        repeat (n) gaps.push_back(($urandom_range(1) == 0) ? t : $urandom_range(0, 2 * t));
      end
      R_NOISE: begin
        n = $urandom_range(0, etwf_pkg::WIRE_BITS + 3);
        repeat (n) gaps.push_back(($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 8 * t));
      end
      default: ;
    endcase
    stamp = ($urandom_range(3) == 0) ? ~etwf_pkg::TIME_W'($urandom_range(0, 4 * t))
                                     : etwf_pkg::TIME_W'($urandom);
    send_edge(stamp, gaps.size() == 0);
    foreach (gaps[i]) begin
      stamp += gaps[i];
      send_edge(stamp, i == gaps.size() - 1);
    end
    replies++;
  endtask

  function automatic reply_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return R_CLEAN;
    if (r < 65) return R_ZERO;
    if (r < 75) return R_OVER;
    if (r < 85) return R_MANY;
    if (r < 89) return R_LONE;
    return R_NOISE;
  endfunction

  task automatic run_phase(int unsigned n_items);
    int unsigned start;
    start = edges_sent;
    while (edges_sent - start < n_items) send_reply(pick_kind());
  endtask

  task automatic write_ticks(logic [etwf_pkg::TICK_W-1:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.ticks = v;
  endtask

  initial begin
    rst_n     = 0;
    cfg_valid = 0;
    cfg_data  = '0;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tlast  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed replies at the reset tick rate
    send_edge(32'h0000_0000, 1);
    send_edge(32'hFFFF_FFFF, 1);
    send_edge(32'hFFFF_FC00, 0);
    send_edge(32'hFFFF_FC00 + 32'd1920, 0);
    send_edge(32'h0000_0380 + 32'd1280, 1);
    send_edge(32'h0000_0100, 0);
    send_edge(32'h0000_0164, 1);
    send_edge(32'h0000_0000, 0);
    send_edge(32'd14080, 1);
    send_edge(32'h0000_1000, 0);
    send_edge(32'h0000_1000 + 32'd13440, 0);
    send_edge(32'h0000_1000 + 32'd15440, 1);
    send_edge(32'd5000, 0);
    send_edge(32'd5320, 0);
    send_edge(32'd6279, 1);
    replies += 7;

    // receiver holds off while edges keep coming, so the input backs up
    hold_ask = 800;
    run_phase(230);

    write_ticks(16'hFFFF);
    idle_on = 0;
    run_phase(230);
    idle_on = 1;

    write_ticks(16'd1);
    run_phase(230);

    write_ticks(16'd0);
    run_phase(230);

    write_ticks(etwf_pkg::TICK_W'($urandom_range(2, 65534)));
    run_phase(230);

    write_ticks(etwf_pkg::TICK_W'($urandom_range(2, 40)));
    run_phase(230);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d edges in %0d replies across six tick rates incl. 640, 65535, 1 and 0.",
             edges_sent, replies);
    $display("Checked %0d frames: ok %0d, zero run %0d, overflow %0d, %s %0d; %0d errors.",
             sb.results, sb.by_status[etwf_pkg::ST_OK], sb.by_status[etwf_pkg::ST_ZERO_RUN],
             sb.by_status[etwf_pkg::ST_OVERFLOW], "too many edges",
             sb.by_status[etwf_pkg::ST_TOO_MANY], sb.bad);
    if (sb.bad == 0 && sb.pending() == 0) begin
      $display("PASS edge_times_to_wire_frame");
    end else begin
      $display("FAIL edge_times_to_wire_frame");
    end
    $finish;
  end

endmodule
